FILE: rtl/text_page_splitter_macros.svh
// Assertion macros shared by the text page splitter RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef TEXT_PAGE_SPLITTER_MACROS_SVH
`define TEXT_PAGE_SPLITTER_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define TPS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Condition must never hold outside reset.
`define TPS_NEVER(label, cond, msg) \
    `TPS_ASSERT(label, !(cond), msg)

`endif

FILE: rtl/tps_pkg.sv
// Shared types and constants of the text page splitter.
// No dependencies; used by every module under rtl.
package tps_pkg;

    localparam logic [7:0]  LeadByte  = 8'h80;
    localparam logic [7:0]  ByteCr    = 8'h0d;
    localparam logic [7:0]  ByteLf    = 8'h0a;
    localparam logic [13:0] BytesMax  = 14'h3fff;
    localparam logic [6:0]  LineMax   = 7'h7f;
    localparam logic [7:0]  ColMax    = 8'hff;

    localparam logic [6:0]  LinesReset = 7'd10;
    localparam logic [7:0]  ColsReset  = 8'd20;

    // configuration register indexes
    localparam logic CfgLinesPerPage   = 1'b0;
    localparam logic CfgColumnsPerLine = 1'b1;

    // result queue
    localparam int QDepth = 4;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    typedef struct packed {
        logic        dropped_lead_byte;
        logic        final_page;
        logic [15:0] page_index;
        logic [13:0] page_byte_count;
    } res_t;

    // up to two results per accepted byte
    typedef struct packed {
        logic [1:0] n;
        res_t       item0;
        res_t       item1;
    } push_t;

    typedef struct packed {
        logic valid;
        res_t item;
    } qhead_t;

endpackage

FILE: rtl/text_page_splitter.sv
// Top level of the text page splitter: front end, result queue, back end.
// Depends on tps_pkg, tps_front, tps_queue, tps_back.
//
//   channel   direction  payload
//   s_        in         tdata[7:0] text_byte, tlast end_of_text
//   m_        out        tdata[13:0] page_byte_count, [29:14] page_index,
//                        tlast final_page, tuser dropped_lead_byte
//   cfg_      in         addr 0 lines_per_page, 1 columns_per_line
//
// One byte per cycle while the result queue has room; state update is a single
// combinational step in the front end. A result is written to the queue at the
// edge that accepts its byte and reaches m_ through the output register.
// s_tready drops only while the 4-entry result queue has fewer than two free slots.
// Reset is synchronous, active low; no clearing pass.
module text_page_splitter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] text_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [13:0] page_byte_count, [29:14] page_index
    output logic        m_tlast,
    output logic        m_tuser     // [0] dropped_lead_byte
);

    tps_pkg::push_t  push;
    tps_pkg::qhead_t head;
    logic            room;
    logic            pop;

    tps_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .byte_valid  (s_tvalid),
        .room        (room),
        .text_byte   (s_tdata),
        .end_of_text (s_tlast),
        .byte_ready  (s_tready),
        .push        (push)
    );

    tps_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .room    (room),
        .head    (head)
    );

    tps_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .pop      (pop),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

FILE: rtl/tps_front.sv
// Front end: accepts text bytes, tracks column/line/page state, emits page results.
// Depends on tps_pkg.
module tps_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic               cfg_addr,
    input  logic [7:0]         cfg_wr_data,
    input  logic               byte_valid,
    input  logic               room,
    input  logic [7:0]         text_byte,
    input  logic               end_of_text,
    output logic               byte_ready,
    output tps_pkg::push_t     push
);

    logic [6:0]  lines_reg;
    logic [7:0]  cols_reg;
    logic [7:0]  col_reg,   col_next;
    logic [6:0]  line_reg,  line_next;
    logic [13:0] bytes_reg, bytes_next;
    logic [15:0] pages_reg, pages_next;
    logic        crp_reg,   crp_next;
    logic        lbp_reg,   lbp_next;

    logic [6:0] eff_lines;
    logic [7:0] eff_cols;
    logic       accept;
    tps_pkg::push_t res;

    assign eff_lines  = (lines_reg == 7'd0) ? 7'd1 : lines_reg;
    assign eff_cols   = (cols_reg < 8'd2) ? 8'd2 : cols_reg;
    assign byte_ready = room;
    assign accept     = byte_valid && room;

    always_comb begin
        logic [7:0]  c;
        logic [6:0]  l;
        logic [13:0] bc;
        logic [15:0] pg;
        logic        cr, lb, drop;
        logic [8:0]  csum;
        tps_pkg::res_t it;

        c = col_reg; l = line_reg; bc = bytes_reg; pg = pages_reg;
        cr = crp_reg; lb = lbp_reg; drop = 1'b0;
        res = '0;
        it  = '0;
        csum = '0;

        if (lb) begin
            lb   = 1'b0;
            bc   = (bc != tps_pkg::BytesMax) ? bc + 14'd1 : bc;
            csum = {1'b0, c} + 9'd2;
            c    = csum[8] ? tps_pkg::ColMax : csum[7:0];
            if (c >= eff_cols) begin
                l = (l != tps_pkg::LineMax) ? l + 7'd1 : l;
                c = 8'd0;
            end
        end else if (cr && text_byte == tps_pkg::ByteLf) begin
            cr = 1'b0;
            bc = (bc != tps_pkg::BytesMax) ? bc + 14'd1 : bc;
        end else begin
            cr = 1'b0;
            if (text_byte >= tps_pkg::LeadByte && end_of_text) begin
                drop = 1'b1;
            end else begin
                if (l >= eff_lines) begin
                    it = '{dropped_lead_byte: 1'b0, final_page: 1'b0,
                           page_index: pg + 16'd1, page_byte_count: bc};
                    res.item0 = it;
                    res.n     = 2'd1;
                    pg = pg + 16'd1; bc = '0; l = '0; c = '0;
                end
                if (text_byte == tps_pkg::ByteCr) begin
                    l  = (l != tps_pkg::LineMax) ? l + 7'd1 : l;
                    c  = 8'd0;
                    cr = 1'b1;
                    bc = (bc != tps_pkg::BytesMax) ? bc + 14'd1 : bc;
                end else if (text_byte == tps_pkg::ByteLf) begin
                    l  = (l != tps_pkg::LineMax) ? l + 7'd1 : l;
                    c  = 8'd0;
                    bc = (bc != tps_pkg::BytesMax) ? bc + 14'd1 : bc;
                end else if (text_byte < tps_pkg::LeadByte) begin
                    bc = (bc != tps_pkg::BytesMax) ? bc + 14'd1 : bc;
                    c  = (c != tps_pkg::ColMax) ? c + 8'd1 : c;
                    if (c >= eff_cols) begin
                        l = (l != tps_pkg::LineMax) ? l + 7'd1 : l;
                        c = 8'd0;
                    end
                end else begin
                    // wide char would straddle the last column: wrap first
                    if ({1'b0, c} + 9'd1 >= {1'b0, eff_cols}) begin
                        l = (l != tps_pkg::LineMax) ? l + 7'd1 : l;
                        c = 8'd0;
                        if (l >= eff_lines) begin
                            it = '{dropped_lead_byte: 1'b0, final_page: 1'b0,
                                   page_index: pg + 16'd1, page_byte_count: bc};
                            if (res.n == 2'd0) res.item0 = it;
                            else               res.item1 = it;
                            res.n = res.n + 2'd1;
                            pg = pg + 16'd1; bc = '0; l = '0; c = '0;
                        end
                    end
                    bc = (bc != tps_pkg::BytesMax) ? bc + 14'd1 : bc;
                    lb = 1'b1;
                end
            end
        end

        if (end_of_text) begin
            it = '{dropped_lead_byte: drop, final_page: 1'b1,
                   page_index: pg + 16'd1, page_byte_count: bc};
            if (res.n == 2'd0) res.item0 = it;
            else               res.item1 = it;
            res.n = res.n + 2'd1;
            c = '0; l = '0; bc = '0; pg = '0; cr = 1'b0; lb = 1'b0;
        end

        col_next   = c;
        line_next  = l;
        bytes_next = bc;
        pages_next = pg;
        crp_next   = cr;
        lbp_next   = lb;
    end

    always_comb begin
        push = res;
        if (!accept) begin
            push.n = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lines_reg <= tps_pkg::LinesReset;
            cols_reg  <= tps_pkg::ColsReset;
            col_reg   <= '0;
            line_reg  <= '0;
            bytes_reg <= '0;
            pages_reg <= '0;
            crp_reg   <= 1'b0;
            lbp_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    tps_pkg::CfgLinesPerPage:   lines_reg <= cfg_wr_data[6:0];
                    tps_pkg::CfgColumnsPerLine: cols_reg  <= cfg_wr_data;
                    default: ;
                endcase
            end
            if (accept) begin
                col_reg   <= col_next;
                line_reg  <= line_next;
                bytes_reg <= bytes_next;
                pages_reg <= pages_next;
                crp_reg   <= crp_next;
                lbp_reg   <= lbp_next;
            end
        end
    end

endmodule

FILE: rtl/tps_queue.sv
// Short result queue between front and back: up to two writes, one read per cycle.
// Depends on tps_pkg and text_page_splitter_macros.svh.
`include "text_page_splitter_macros.svh"

module tps_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  tps_pkg::push_t  push,
    input  logic            pop,
    output logic            room,
    output tps_pkg::qhead_t head
);

    tps_pkg::res_t                 entries [tps_pkg::QDepth];
    logic [tps_pkg::QPtrW-1:0]     wp_reg, wp_next;
    logic [tps_pkg::QPtrW-1:0]     rp_reg, rp_next;
    logic [tps_pkg::QCntW-1:0]     cnt_reg, cnt_next;
    logic [tps_pkg::QPtrW-1:0]     wp_plus1;

    assign wp_plus1   = wp_reg + 1'b1;
    assign room       = cnt_reg <= tps_pkg::QCntW'(tps_pkg::QDepth - 2);
    assign head.valid = cnt_reg != '0;
    assign head.item  = entries[rp_reg];

    always_comb begin
        wp_next  = wp_reg + tps_pkg::QPtrW'(push.n);
        rp_next  = rp_reg + tps_pkg::QPtrW'(pop);
        cnt_next = cnt_reg + tps_pkg::QCntW'(push.n) - tps_pkg::QCntW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.n != 2'd0) begin
            entries[wp_reg] <= push.item0;
        end
        if (push.n == 2'd2) begin
            entries[wp_plus1] <= push.item1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    `TPS_ASSERT(a_no_overflow, (push.n != 2'd0) |-> ((cnt_reg + push.n) <= tps_pkg::QDepth), "result queue overflow")
    `TPS_NEVER(a_no_underflow, pop && (cnt_reg == '0), "pop from empty result queue")
    `TPS_ASSERT(a_ptr_track, (wp_reg - rp_reg) == tps_pkg::QPtrW'(cnt_reg), "queue pointers disagree with count")

endmodule

FILE: rtl/tps_back.sv
// Back end: moves queued page results into the output register of the result stream.
// Depends on tps_pkg.
module tps_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  tps_pkg::qhead_t head,
    output logic            pop,
    input  logic            m_tready,
    output logic            m_tvalid,
    output logic [31:0]     m_tdata,
    output logic            m_tlast,
    output logic            m_tuser
);

    logic          valid_reg;
    tps_pkg::res_t out_reg;

    assign pop      = head.valid && (!valid_reg || m_tready);
    assign m_tvalid = valid_reg;
    assign m_tdata  = {2'b00, out_reg.page_index, out_reg.page_byte_count};
    assign m_tlast  = out_reg.final_page;
    assign m_tuser  = out_reg.dropped_lead_byte;

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_reg <= head.item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pop) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

endmodule

FILE: tb/page_checker.sv
// Scoreboard for the text page splitter: tracks config writes and byte transfers,
// predicts each page result and compares it with what leaves the m_ channel.
// Depends on tps_pkg only.
module page_checker
    import tps_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        m_tlast,
    input  logic        m_tuser,
    output int          mismatch_count,
    output int          pages_awaited
);
    timeunit 1ns;
    timeprecision 1ps;

    res_t        pages_expected [$];

    logic [6:0]  lines_cfg;
    logic [7:0]  cols_cfg;
    logic [7:0]  col_pos;
    logic [6:0]  line_pos;
    logic [13:0] page_bytes;
    logic [15:0] page_num;
    logic        cr_seen;
    logic        lead_seen;

    function automatic logic [6:0] lines_limit();
        return (lines_cfg == 7'd0) ? 7'd1 : lines_cfg;
    endfunction

    function automatic logic [7:0] cols_limit();
        return (cols_cfg < 8'd2) ? 8'd2 : cols_cfg;
    endfunction

    task automatic clear_text();
        col_pos    = '0;
        line_pos   = '0;
        page_bytes = '0;
        page_num   = '0;
        cr_seen    = 1'b0;
        lead_seen  = 1'b0;
    endtask

    task automatic tally_byte();
        if (page_bytes != BytesMax)
            page_bytes++;
    endtask

    task automatic advance_line();
        if (line_pos != LineMax)
            line_pos++;
        col_pos = '0;
    endtask

    task automatic close_page(input logic last_page, input logic dropped);
        res_t page;
        page.page_byte_count   = page_bytes;
        page.page_index        = page_num + 16'd1;
        page.final_page        = last_page;
        page.dropped_lead_byte = dropped;
        pages_expected.insert(pages_expected.size(), page);
        page_num   = page_num + 16'd1;
        page_bytes = '0;
        line_pos   = '0;
        col_pos    = '0;
        cr_seen    = 1'b0;
    endtask

    task automatic place_byte(input logic [7:0] b, input logic eot);
        logic       dropped;
        logic [8:0] wide_col;
        dropped = 1'b0;
        if (lead_seen) begin
            lead_seen = 1'b0;
            tally_byte();
            wide_col = {1'b0, col_pos} + 9'd2;
            col_pos  = (wide_col > 9'd255) ? ColMax : wide_col[7:0];
            if (col_pos >= cols_limit())
                advance_line();
        end else if (cr_seen && b == ByteLf) begin
            cr_seen = 1'b0;
            tally_byte();
        end else begin
            cr_seen = 1'b0;
            if (b >= LeadByte && eot) begin
                dropped = 1'b1;
            end else begin
                if (line_pos >= lines_limit())
                    close_page(1'b0, 1'b0);
                if (b == ByteCr) begin
                    advance_line();
                    cr_seen = 1'b1;
                    tally_byte();
                end else if (b == ByteLf) begin
                    advance_line();
                    tally_byte();
                end else if (b < LeadByte) begin
                    tally_byte();
                    if (col_pos != ColMax)
                        col_pos++;
                    if (col_pos >= cols_limit())
                        advance_line();
                end else begin
                    // wide char never straddles the last column
                    if ({1'b0, col_pos} + 9'd1 >= {1'b0, cols_limit()}) begin
                        advance_line();
                        if (line_pos >= lines_limit())
                            close_page(1'b0, 1'b0);
                    end
                    tally_byte();
                    lead_seen = 1'b1;
                end
            end
        end
        if (eot) begin
            close_page(1'b1, dropped);
            clear_text();
        end
    endtask

    function automatic int differs(input string field, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            return 1;
        end
        return 0;
    endfunction

    task automatic check_page();
        res_t want;
        if (pages_expected.size() == 0) begin
            $error("page transfer with none expected: page_byte_count %0d, page_index %0d",
                   m_tdata[13:0], m_tdata[29:14]);
            mismatch_count++;
        end else begin
            want = pages_expected.pop_front();
            mismatch_count += differs("page_byte_count", want.page_byte_count, m_tdata[13:0]);
            mismatch_count += differs("page_index", want.page_index, m_tdata[29:14]);
            mismatch_count += differs("final_page", want.final_page, m_tlast);
            mismatch_count += differs("dropped_lead_byte", want.dropped_lead_byte, m_tuser);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            lines_cfg = LinesReset;
            cols_cfg  = ColsReset;
            clear_text();
            pages_expected.delete();
        end else begin
            // results leave before this edge's byte can add new ones
            if (m_tvalid && m_tready)
                check_page();
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CfgLinesPerPage:   lines_cfg = cfg_wr_data[6:0];
                    CfgColumnsPerLine: cols_cfg  = cfg_wr_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                place_byte(s_tdata, s_tlast);
        end
        pages_awaited = pages_expected.size();
    end

endmodule

FILE: tb/testbench.sv
// Top of the text page splitter testbench: clock, reset, byte stimulus, config
// writes and random back-pressure. Checking is done by page_checker.
// Depends on tps_pkg, page_checker and text_page_splitter.
module testbench;
    import tps_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QuietLimit = 2000;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic        cfg_addr    = CfgLinesPerPage;
    logic [7:0]  cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = '0;
    logic        s_tlast     = 1'b0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    int mismatch_count;
    int pages_awaited;
    int sender_idle_pct   = 0;
    int receiver_stall_pct = 0;
    int quiet_cycles      = 0;

    text_page_splitter DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    page_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wr_data    (cfg_wr_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .pages_awaited  (pages_awaited)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= QuietLimit);
        $display("simulation failed");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b, input logic eot);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eot;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // drop valid and let every predicted page arrive, then some slack
    task automatic wait_empty(input int slack);
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pages_awaited != 0);
        repeat (slack) @(negedge aclk);
    endtask

    task automatic write_regs(input logic [6:0] lines, input logic [7:0] cols);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= CfgLinesPerPage;
        cfg_wr_data <= {1'b0, lines};
        @(negedge aclk);
        cfg_addr    <= CfgColumnsPerLine;
        cfg_wr_data <= cols;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic int text_length();
        return ($urandom_range(3) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 40);
    endfunction

    task automatic random_phase(input int n_bytes, input bit hold_each_text);
        int         sent;
        int         text_left;
        int         pick;
        logic [7:0] trail;
        sent      = 0;
        text_left = text_length();
        while (sent < n_bytes) begin
            pick = $urandom_range(99);
            if (text_left == 1) begin
                if (pick < 30)
                    send_byte(8'($urandom_range(128, 255)), 1'b1);
                else
                    send_byte(8'($urandom), 1'b1);
                sent++;
                if (hold_each_text)
                    wait_empty(0);
                text_left = text_length();
            end else if (pick < 20 && text_left > 2) begin
                case ($urandom_range(3))
                    0:       trail = ByteCr;
                    1:       trail = ByteLf;
                    2:       trail = 8'h00;
                    default: trail = 8'($urandom);
                endcase
                send_byte(8'($urandom_range(128, 255)), 1'b0);
                send_byte(trail, 1'b0);
                sent      += 2;
                text_left -= 2;
            end else if (pick < 28 && text_left > 2) begin
                send_byte(ByteCr, 1'b0);
                send_byte(ByteLf, 1'b0);
                sent      += 2;
                text_left -= 2;
            end else begin
                if (pick < 36)
                    send_byte(ByteCr, 1'b0);
                else if (pick < 44)
                    send_byte(ByteLf, 1'b0);
                else if (pick < 50)
                    send_byte(8'h00, 1'b0);
                else if (pick < 85)
                    send_byte(8'($urandom_range(32, 126)), 1'b0);
                else
                    send_byte(8'($urandom), 1'b0);
                sent++;
                text_left--;
            end
        end
    endtask

    initial begin
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset geometry: narrow, CR, LF, CR+LF, wide with CR trail, dangling lead
        send_byte(8'h00, 1'b0);
        send_byte(8'h7f, 1'b0);
        send_byte(ByteCr, 1'b0);
        send_byte(ByteLf, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(LeadByte, 1'b0);
        send_byte(ByteCr, 1'b0);
        send_byte(ByteLf, 1'b0);
        send_byte(ByteCr, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'hff, 1'b1);
        // text made of a lone lead byte
        send_byte(8'hc3, 1'b1);

        // out-of-range registers act as one line, two columns
        wait_empty(6);
        write_regs(7'd0, 8'd0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b0);
        send_byte(8'h43, 1'b0);
        send_byte(ByteCr, 1'b0);
        send_byte(ByteLf, 1'b0);
        send_byte(8'h90, 1'b0);
        send_byte(ByteCr, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h7f, 1'b1);

        for (int p = 0; p < 8; p++) begin
            wait_empty(6);
            case (p)
                0:       write_regs(7'd1, 8'd2);
                1:       write_regs(7'd2, 8'd3);
                2:       write_regs(7'd0, 8'd1);
                3:       write_regs(7'd3, 8'd6);
                4:       write_regs(7'd64, 8'd255);
                5:       write_regs(7'd127, 8'd255);
                6:       write_regs(7'($urandom_range(1, 64)), 8'($urandom_range(2, 255)));
                default: write_regs(7'd4, 8'd2);
            endcase
            case (p % 4)
                0: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1: begin
                    sender_idle_pct    = 45;
                    receiver_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 45;
                end
                default: begin
                    sender_idle_pct    = 15;
                    receiver_stall_pct = 15;
                end
            endcase
            random_phase(225, p == 2);
        end

        wait_empty(8);
        if (mismatch_count == 0 && pages_awaited == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
